### hdl/tcw_pkg.sv
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] INIT_ATTR    = 8'h0F;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic       use_cursor;
        logic [6:0] col;
        logic [4:0] row;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic take_item;
        logic exec_put;
        logic read_issue;
        logic copy;
        logic fill;
        logic fill_init;
        logic ptr_clr;
        logic ptr_inc;
        logic cur_home;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       scroll;
        logic       ptr_copy_last;
        logic       ptr_last;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

### hdl/tcw_ctrl.sv
// Sequencer for the text console: item dispatch, scroll, clear and reset sweeps.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_BLANK = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_init = 1'b1;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.func)
                    FUNC_PUT: begin
                        o_cmd.exec_put = 1'b1;
                        if (i_stat.scroll) begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = S_COPY;
                        end else if (i_stat.out_free) begin
                            o_cmd.load_out = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    FUNC_READ: begin
                        o_cmd.read_issue = 1'b1;
                        n_state          = S_FIN;
                    end
                    FUNC_CLEAR: begin
                        o_cmd.ptr_clr  = 1'b1;
                        o_cmd.cur_home = 1'b1;
                        n_state        = S_CLEAR;
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_out = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                endcase
            end
            S_COPY: begin
                o_cmd.copy    = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_stat.ptr_copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last pending copy write lands here
                n_state = S_BLANK;
            end
            S_BLANK, S_CLEAR: begin
                o_cmd.fill = 1'b1;
                if (i_stat.ptr_last) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/tcw_datapath.sv
// Screen store, cursor, sweep pointer and result register of the text console.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire t_cmd      i_cmd,
    output t_stat          o_stat
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rdata;

    logic [7:0]    r_def_attr;
    logic [1:0]    r_func;
    logic [7:0]    r_char;
    logic [7:0]    r_attr;
    logic [CW-1:0] r_pos_col;
    logic [RW-1:0] r_pos_row;
    logic [CW-1:0] r_cur_col;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] n_cur_col;
    logic [RW-1:0] n_cur_row;
    logic [AW-1:0] r_ptr;
    logic          r_cp_valid;
    logic [AW-1:0] r_cp_addr;
    logic          r_out_valid;
    t_out_item     r_out_data;

    logic [CW-1:0] sat_col;
    logic [RW-1:0] sat_row;
    logic [AW-1:0] pos_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [7:0]    eff_attr;
    logic          wrap_row;
    logic          scroll;
    logic          out_free;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_attr <= INIT_ATTR;
        end else if (i_cfg_valid) begin
            r_def_attr <= i_cfg_data;
        end
    end

    // clamp explicit position into the screen
    always_comb begin
        if (32'(i_in_data.col) >= 32'(COLUMNS)) begin
            sat_col = CW'(COLUMNS - 1);
        end else begin
            sat_col = CW'(i_in_data.col);
        end
        if (32'(i_in_data.row) >= 32'(ROWS)) begin
            sat_row = RW'(ROWS - 1);
        end else begin
            sat_row = RW'(i_in_data.row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_func <= i_in_data.func;
            r_char <= i_in_data.char_code;
            r_attr <= i_in_data.attribute;
            if (i_in_data.use_cursor) begin
                r_pos_col <= r_cur_col;
                r_pos_row <= r_cur_row;
            end else begin
                r_pos_col <= sat_col;
                r_pos_row <= sat_row;
            end
        end
    end

    assign pos_addr = AW'(32'(r_pos_row) * COLUMNS + 32'(r_pos_col));
    assign eff_attr = (r_attr == 8'd0) ? r_def_attr : r_attr;

    // cursor advance
    always_comb begin
        wrap_row  = (r_char == NEWLINE_CHAR) || (r_pos_col == CW'(COLUMNS - 1));
        scroll    = wrap_row && (r_pos_row == RW'(ROWS - 1));
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (i_cmd.cur_home) begin
            n_cur_col = '0;
            n_cur_row = '0;
        end else if (i_cmd.exec_put) begin
            if (wrap_row) begin
                n_cur_col = '0;
                n_cur_row = scroll ? r_pos_row : r_pos_row + RW'(1);
            end else begin
                n_cur_col = r_pos_col + CW'(1);
                n_cur_row = r_pos_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
        end
    end

    // sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + AW'(1);
        end
    end

    // copy: read one row ahead, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_valid <= 1'b0;
        end else begin
            r_cp_valid <= i_cmd.copy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy) begin
            r_cp_addr <= r_ptr;
        end
    end

    assign rd_en   = i_cmd.copy || i_cmd.read_issue;
    assign rd_addr = i_cmd.copy ? AW'(32'(r_ptr) + COLUMNS) : pos_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_addr;
        wr_data = {eff_attr, r_char};
        if (r_cp_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_addr;
            wr_data = r_rdata;
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            wr_data = {(i_cmd.fill_init ? INIT_ATTR : r_def_attr), BLANK_CHAR};
        end else if (i_cmd.exec_put && (r_char != NEWLINE_CHAR)) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // result register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.cursor_col <= 7'(n_cur_col);
            r_out_data.cursor_row <= 5'(n_cur_row);
            if (r_func == FUNC_READ) begin
                r_out_data.read_char <= r_rdata[7:0];
                r_out_data.read_attr <= r_rdata[15:8];
            end else begin
                r_out_data.read_char <= 8'd0;
                r_out_data.read_attr <= 8'd0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.func          = r_func;
    assign o_stat.scroll        = scroll;
    assign o_stat.ptr_copy_last = (r_ptr == AW'(CELLS - COLUMNS - 1));
    assign o_stat.ptr_last      = (r_ptr == AW'(CELLS - 1));
    assign o_stat.out_free      = out_free;

endmodule

`default_nettype wire

### hdl/text_console_char_writer.sv
// Top level of the text console character writer: controller plus datapath.
//
// Text-mode screen of COLUMNS x ROWS cells (character low byte, attribute
// high byte) with a cursor. Input beats on i_in_* carry one item: put a
// character (at col/row or at the cursor), read a cell, or clear and home.
// Each accepted item gives exactly one output beat on o_out_* with the cursor
// after the item and, for a read, the cell contents.
// Config beats on i_cfg_* set the default attribute; o_cfg_ready is always
// high, writes are meant to land while the block is idle.
// Work per item up to the result register load (the block returns to idle
// after each load before it accepts the next item):
//   put without scroll, unused code: result load straight from execute
//   read: registered memory read, then result load
//   put that scrolls: one cell per cycle copy of each cell one row up, a
//     drain state, then a blank fill of the bottom row
//   clear: one cell per cycle blank sweep over all cells, cursor home
// After reset a sweep over all COLUMNS*ROWS cells fills the screen with
// blanks (attribute 0x0F); o_in_ready stays low until it finishes.
// The result sits in an output register: while the receiver stalls, the
// next item is still accepted and worked; it waits only to hand off its own
// result.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // config register write is always taken
    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    // one item in flight: an accepted beat closes the input side next cycle
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still open after accepting a beat");

    // result register is never overwritten while a result is pending
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a pending beat");

    // output valid only rises from a result load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("output valid rose without a result load");

    // scroll copy and blank fill never share the write port
    a_copy_fill_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.copy && w_cmd.fill))
        else $error("copy and fill commanded together");

endmodule

`default_nettype wire
